// ===== sv/pkcs7_pkg.sv =====
// Shared types and constants for the PKCS#7 pad/unpad stream unit.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package pkcs7_pkg;

   // Cipher block size in bytes and the widths that follow from it
   localparam int BLOCK_BYTES = 16;
   localparam int PHASE_W     = $clog2(BLOCK_BYTES);
   localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
   localparam int BYTE_W      = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIRECTION = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_EMPTY = 1'b1;

   // Direction codes
   localparam logic DIR_ADD    = 1'b0;
   localparam logic DIR_REMOVE = 1'b1;

   // One classified input item as handed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0]  byte_value;
      logic               has_byte;
      logic               is_last;
      logic               direction;
      logic               pad_empty;
      logic [PHASE_W-1:0] phase;       // length mod block size after this item
      logic               seen_full;   // at least one whole block so far
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CLOSE,
      BK_PAD,
      BK_DRAIN
   } back_state_type;

endpackage

// ===== sv/pkcs7_front.sv =====
// Front end: holds the configuration registers, tracks message length
// and classifies each accepted item into a command. Uses pkcs7_pkg.
`timescale 1ns / 1ps

module pkcs7_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pkcs7_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic                                 csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pkcs7_pkg::BYTE_W-1:0]         req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 cmd_valid,
   input  logic                                 cmd_full,
   output pkcs7_pkg::cmd_type                   cmd
);

   logic                          direction_ff, direction_in;
   logic                          pad_empty_ff, pad_empty_in;
   logic [pkcs7_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                          seen_ff, seen_in;
   logic [pkcs7_pkg::PHASE_W-1:0] phase_next;
   logic                          seen_next;
   logic                          accept;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;

   // Write configuration registers
   always_comb begin
      direction_in = direction_ff;
      pad_empty_in = pad_empty_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pkcs7_pkg::CSR_DIRECTION: direction_in = csr_wdata;
            pkcs7_pkg::CSR_PAD_EMPTY: pad_empty_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the block phase on every data byte
   always_comb begin
      phase_next = phase_ff;
      seen_next  = seen_ff;
      if (req_tuser) begin
         if (phase_ff == pkcs7_pkg::PHASE_W'(pkcs7_pkg::BLOCK_BYTES - 1)) begin
            phase_next = '0;
            seen_next  = 1'b1;
         end else begin
            phase_next = phase_ff + 1'b1;
         end
      end
   end

   // Hold the counters, clear them when a message closes
   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      if (accept) begin
         phase_in = req_tlast ? '0 : phase_next;
         seen_in  = req_tlast ? 1'b0 : seen_next;
      end
   end

   // Drop bare non-last items, queue everything else
   assign cmd_valid      = accept && (req_tuser || req_tlast);
   assign cmd.byte_value = req_tdata;
   assign cmd.has_byte   = req_tuser;
   assign cmd.is_last    = req_tlast;
   assign cmd.direction  = direction_ff;
   assign cmd.pad_empty  = pad_empty_ff;
   assign cmd.phase      = phase_next;
   assign cmd.seen_full  = seen_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= pkcs7_pkg::DIR_ADD;
         pad_empty_ff <= 1'b0;
         phase_ff     <= '0;
         seen_ff      <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         pad_empty_ff <= pad_empty_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

// ===== sv/pkcs7_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Uses pkcs7_pkg for the command type and depth.
`timescale 1ns / 1ps

module pkcs7_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pkcs7_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pkcs7_pkg::cmd_type head_cmd
);

   pkcs7_pkg::cmd_type             mem_ff [pkcs7_pkg::QUEUE_DEPTH];
   logic [pkcs7_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pkcs7_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pkcs7_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                           do_push, do_pop;

   assign full       = (count_ff == pkcs7_pkg::QCNT_W'(pkcs7_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pkcs7_pkg::QPTR_W'(pkcs7_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pkcs7_pkg::QPTR_W'(pkcs7_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/pkcs7_back.sv =====
// Back end: executes queued commands, holds the tail window for removal,
// appends or checks padding and drives the result register. Uses pkcs7_pkg.
`timescale 1ns / 1ps

module pkcs7_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  pkcs7_pkg::cmd_type             head_cmd,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pkcs7_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int B = pkcs7_pkg::BLOCK_BYTES;

   pkcs7_pkg::back_state_type      state_ff, state_in;
   pkcs7_pkg::cmd_type             cmd_ff, cmd_in;
   logic [pkcs7_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pkcs7_pkg::BYTE_W-1:0]   pad_ff, pad_in;
   logic [pkcs7_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [pkcs7_pkg::BYTE_W-1:0]   window_ff [B];
   logic [pkcs7_pkg::BYTE_W-1:0]   window_in [B];

   logic                           out_valid_ff;
   logic [pkcs7_pkg::BYTE_W-1:0]   out_byte_ff;
   logic                           out_has_ff, out_last_ff, out_status_ff;

   logic                           can_issue;
   logic                           emit;
   logic [pkcs7_pkg::BYTE_W-1:0]   e_byte;
   logic                           e_has, e_last, e_status;

   logic [pkcs7_pkg::BYTE_W-1:0]   pad_value;
   logic                           pad_range_ok;
   logic                           pad_match;
   logic                           unpad_ok;
   logic [pkcs7_pkg::CNT_W-1:0]    keep;
   logic [pkcs7_pkg::CNT_W-1:0]    add_count;
   logic                           add_empty;

   assign can_issue = !out_valid_ff || rsp_tready;

   // Check trailing pad bytes of the window in parallel
   always_comb begin
      pad_value    = window_ff[B-1];
      pad_range_ok = (pad_value != '0) &&
                     (pad_value <= pkcs7_pkg::BYTE_W'(B));
      pad_match    = 1'b1;
      for (int i = 0; i < B; i++) begin
         if ((pkcs7_pkg::BYTE_W'(i) < pad_value) && (window_ff[B-1-i] != pad_value)) begin
            pad_match = 1'b0;
         end
      end
      unpad_ok = (cmd_ff.phase == '0) && cmd_ff.seen_full &&
                 (fill_ff == pkcs7_pkg::CNT_W'(B)) && pad_range_ok && pad_match;
      keep      = pkcs7_pkg::CNT_W'(B) - pkcs7_pkg::CNT_W'(pad_value);
      add_count = pkcs7_pkg::CNT_W'(B) - pkcs7_pkg::CNT_W'(cmd_ff.phase);
      add_empty = (cmd_ff.phase == '0) && !cmd_ff.seen_full;
   end

   // Sequence commands: byte action, then close, pad or drain bursts
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      fill_in   = fill_ff;
      window_in = window_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      e_byte    = '0;
      e_has     = 1'b0;
      e_last    = 1'b0;
      e_status  = 1'b0;

      unique case (state_ff)
         pkcs7_pkg::BK_IDLE: begin
            if (head_valid && can_issue) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               if (head_cmd.has_byte) begin
                  if (head_cmd.direction == pkcs7_pkg::DIR_ADD) begin
                     emit   = 1'b1;
                     e_byte = head_cmd.byte_value;
                     e_has  = 1'b1;
                  end else begin
                     // shift the window, newest byte at the top
                     for (int i = 0; i < B - 1; i++) begin
                        window_in[i] = window_ff[i+1];
                     end
                     window_in[B-1] = head_cmd.byte_value;
                     if (fill_ff == pkcs7_pkg::CNT_W'(B)) begin
                        emit   = 1'b1;
                        e_byte = window_ff[0];
                        e_has  = 1'b1;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
               end
               if (head_cmd.is_last) begin
                  state_in = pkcs7_pkg::BK_CLOSE;
               end
            end
         end

         pkcs7_pkg::BK_CLOSE: begin
            if (can_issue) begin
               fill_in = '0;
               if (cmd_ff.direction == pkcs7_pkg::DIR_ADD) begin
                  if (add_empty && !cmd_ff.pad_empty) begin
                     emit     = 1'b1;
                     e_last   = 1'b1;
                     state_in = pkcs7_pkg::BK_IDLE;
                  end else begin
                     cnt_in   = add_count;
                     pad_in   = pkcs7_pkg::BYTE_W'(add_count);
                     state_in = pkcs7_pkg::BK_PAD;
                  end
               end else if (!unpad_ok) begin
                  emit     = 1'b1;
                  e_last   = 1'b1;
                  e_status = 1'b1;
                  state_in = pkcs7_pkg::BK_IDLE;
               end else if (keep == '0) begin
                  emit     = 1'b1;
                  e_last   = 1'b1;
                  state_in = pkcs7_pkg::BK_IDLE;
               end else begin
                  cnt_in   = keep;
                  state_in = pkcs7_pkg::BK_DRAIN;
               end
            end
         end

         pkcs7_pkg::BK_PAD: begin
            if (can_issue) begin
               emit   = 1'b1;
               e_byte = pad_ff;
               e_has  = 1'b1;
               e_last = (cnt_ff == pkcs7_pkg::CNT_W'(1));
               cnt_in = cnt_ff - 1'b1;
               if (e_last) begin
                  state_in = pkcs7_pkg::BK_IDLE;
               end
            end
         end

         pkcs7_pkg::BK_DRAIN: begin
            if (can_issue) begin
               emit   = 1'b1;
               e_byte = window_ff[0];
               e_has  = 1'b1;
               e_last = (cnt_ff == pkcs7_pkg::CNT_W'(1));
               cnt_in = cnt_ff - 1'b1;
               for (int i = 0; i < B - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[B-1] = '0;
               if (e_last) begin
                  state_in = pkcs7_pkg::BK_IDLE;
               end
            end
         end

         default: state_in = pkcs7_pkg::BK_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkcs7_pkg::BK_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: window, held command, result register
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pad_ff    <= pad_in;
      window_ff <= window_in;
      if (emit) begin
         out_byte_ff   <= e_byte;
         out_has_ff    <= e_has;
         out_last_ff   <= e_last;
         out_status_ff <= e_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_status_ff, out_has_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   // Window count never runs past the block size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= pkcs7_pkg::CNT_W'(B))
      else $error("window fill exceeds block size");

   // A burst state always has bytes left to send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pkcs7_pkg::BK_PAD || state_ff == pkcs7_pkg::BK_DRAIN) |-> cnt_ff != '0)
      else $error("burst state with zero count");

   // The final result of a message returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (emit && e_last) |=> state_ff == pkcs7_pkg::BK_IDLE)
      else $error("sequencer not idle after closing result");

   // A closing command, once taken, moves the sequencer to close
   assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.is_last) |=> state_ff == pkcs7_pkg::BK_CLOSE)
      else $error("closing command did not enter close");
`endif

endmodule

// ===== sv/pkcs7_pad_unpad_stream_unit.sv =====
// PKCS#7 pad/unpad stream unit, 16-byte blocks: top level.
// Joins pkcs7_front, pkcs7_queue and pkcs7_back; uses pkcs7_pkg.
//
// Usage:
//   req_ channel: one item per handshake; tdata carries a message byte,
//   tuser says the byte is present, tlast closes the message.
//   rsp_ channel: one result per handshake; tdata is the output byte,
//   tuser holds {status, has_byte}, tlast marks the last result.
//   csr_ port: write direction (index 0: 0 add, 1 remove) and the
//   empty-message pad enable (index 1) while the block is idle.
// Timing:
//   An add-mode byte reaches rsp_ via the command queue and the result
//   register, one byte per cycle while rsp_tready is high; in remove
//   mode a byte leaves once 16 newer bytes push it out. At a close the
//   back end decides in its close state, then sends the pad bytes (add)
//   or the unpadded window (remove), one per cycle while rsp_tready is
//   high, up to 16. A 4-entry command queue keeps input flowing until it fills.
// Reset clears the counters, queue and result valid flag; the tail window
// needs no clearing. A stalled rsp_tready holds the result register and,
// once the queue fills, deasserts req_tready.
`timescale 1ns / 1ps

module pkcs7_pad_unpad_stream_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pkcs7_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic                                csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pkcs7_pkg::BYTE_W-1:0]        req_tdata,   // byte_value
   input  logic                                req_tuser,   // has_byte
   input  logic                                req_tlast,   // is_last
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pkcs7_pkg::BYTE_W-1:0]        rsp_tdata,   // out_byte
   output logic [1:0]                          rsp_tuser,   // {status, out_has_byte}
   output logic                                rsp_tlast    // out_last
);

   logic               cmd_valid;
   logic               cmd_full;
   pkcs7_pkg::cmd_type cmd;
   logic               head_valid;
   pkcs7_pkg::cmd_type head_cmd;
   logic               pop;

   pkcs7_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd_full   (cmd_full),
      .cmd        (cmd)
   );

   pkcs7_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_valid),
      .push_cmd   (cmd),
      .full       (cmd_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pkcs7_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
